/* hdl/hkpc_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// hkpc_pkg
// Shared types, constants and code tables for the host key to PC scan code
// translator.
// ============================================================================
package hkpc_pkg;

    localparam logic [15:0] VK_PAUSE   = 16'h0013;
    localparam logic [7:0]  PFX_EXT    = 8'he0;
    localparam logic [7:0]  PFX_BREAK  = 8'hf0;
    localparam logic [7:0]  S1_BREAK   = 8'h80;
    localparam logic [7:0]  DIRECT_MAX = 8'h58;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_UNSUP = 1'b1;

    localparam logic SET_1 = 1'b0;
    localparam logic SET_2 = 1'b1;

    localparam logic [3:0] PAUSE_LEN_S1 = 4'd6;
    localparam logic [3:0] PAUSE_LEN_S2 = 4'd8;

    // One classified key event, as handed from front to back.
    typedef struct packed {
        logic       pause;   // emit the fixed Pause sequence
        logic       set2;    // Pause variant select
        logic       empty;   // single result without a byte
        logic       status;
        logic [3:0] nbytes;  // result count, 1..8
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
    } t_desc;

    localparam logic [7:0] SET2_TAB [0:88] = '{
        8'h00, 8'h76, 8'h16, 8'h1e, 8'h26, 8'h25, 8'h2e, 8'h36,
        8'h3d, 8'h3e, 8'h46, 8'h45, 8'h4e, 8'h55, 8'h66, 8'h0d,
        8'h15, 8'h1d, 8'h24, 8'h2d, 8'h2c, 8'h35, 8'h3c, 8'h43,
        8'h44, 8'h4d, 8'h54, 8'h5b, 8'h5a, 8'h14, 8'h1c, 8'h1b,
        8'h23, 8'h2b, 8'h34, 8'h33, 8'h3b, 8'h42, 8'h4b, 8'h4c,
        8'h52, 8'h0e, 8'h12, 8'h5d, 8'h1a, 8'h22, 8'h21, 8'h2a,
        8'h32, 8'h31, 8'h3a, 8'h41, 8'h49, 8'h4a, 8'h59, 8'h7c,
        8'h11, 8'h29, 8'h58, 8'h05, 8'h06, 8'h04, 8'h0c, 8'h03,
        8'h0b, 8'h83, 8'h0a, 8'h01, 8'h09, 8'h77, 8'h7e, 8'h6c,
        8'h75, 8'h7d, 8'h7b, 8'h6b, 8'h73, 8'h74, 8'h79, 8'h69,
        8'h72, 8'h7a, 8'h70, 8'h71, 8'h00, 8'h00, 8'h00, 8'h78,
        8'h07
    };

    localparam logic [7:0] PAUSE_S1 [0:7] = '{
        8'he1, 8'h1d, 8'h45, 8'he1, 8'h9d, 8'hc5, 8'h00, 8'h00
    };
    localparam logic [7:0] PAUSE_S2 [0:7] = '{
        8'he1, 8'h14, 8'h77, 8'he1, 8'hf0, 8'h14, 8'hf0, 8'h77
    };

    // Set-1 to set-2 translation; zero marks no translation.
    function automatic logic [7:0] set2_code(input logic [7:0] code);
        logic [7:0] res;
        res = 8'h00;
        if (code <= DIRECT_MAX) begin
            res = SET2_TAB[code[6:0]];
        end
        return res;
    endfunction

    function automatic logic [7:0] pause_byte(input logic set2, input logic [2:0] idx);
        return set2 ? PAUSE_S2[idx] : PAUSE_S1[idx];
    endfunction

    // Lower-case ASCII to set-1 make code; zero marks a hole.
    function automatic logic [7:0] ascii_code(input logic [6:0] ch);
        logic [7:0] res;
        case (ch)
            7'h08: res = 8'h0e;
            7'h09: res = 8'h0f;
            7'h0d: res = 8'h1c;
            7'h1b: res = 8'h01;
            7'h20: res = 8'h39;
            7'h27: res = 8'h28;
            7'h2c: res = 8'h33;
            7'h2d: res = 8'h0c;
            7'h2e: res = 8'h34;
            7'h2f: res = 8'h35;
            7'h30: res = 8'h0b;
            7'h31: res = 8'h02;
            7'h32: res = 8'h03;
            7'h33: res = 8'h04;
            7'h34: res = 8'h05;
            7'h35: res = 8'h06;
            7'h36: res = 8'h07;
            7'h37: res = 8'h08;
            7'h38: res = 8'h09;
            7'h39: res = 8'h0a;
            7'h3b: res = 8'h27;
            7'h3d: res = 8'h0d;
            7'h5b: res = 8'h1a;
            7'h5c: res = 8'h2b;
            7'h5d: res = 8'h1b;
            7'h60: res = 8'h29;
            7'h61: res = 8'h1e;
            7'h62: res = 8'h30;
            7'h63: res = 8'h2e;
            7'h64: res = 8'h20;
            7'h65: res = 8'h12;
            7'h66: res = 8'h21;
            7'h67: res = 8'h22;
            7'h68: res = 8'h23;
            7'h69: res = 8'h17;
            7'h6a: res = 8'h24;
            7'h6b: res = 8'h25;
            7'h6c: res = 8'h26;
            7'h6d: res = 8'h32;
            7'h6e: res = 8'h31;
            7'h6f: res = 8'h18;
            7'h70: res = 8'h19;
            7'h71: res = 8'h10;
            7'h72: res = 8'h13;
            7'h73: res = 8'h1f;
            7'h74: res = 8'h14;
            7'h75: res = 8'h16;
            7'h76: res = 8'h2f;
            7'h77: res = 8'h11;
            7'h78: res = 8'h2d;
            7'h79: res = 8'h15;
            7'h7a: res = 8'h2c;
            default: res = 8'h00;
        endcase
        return res;
    endfunction

endpackage

/* hdl/hkpc_front.sv */
`timescale 1ns / 1ps
// ============================================================================
// hkpc_front
// Holds the scan set register and classifies each key event into a
// descriptor for the emitter.
// ============================================================================
module hkpc_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr,
    input  logic                i_cfg_scan_set,
    input  logic [8:0]          i_host_code,
    input  logic [15:0]         i_virtual_key,
    input  logic                i_key_down,
    output hkpc_pkg::t_desc     o_desc
);

    logic       r_scan_set;
    logic       ext;
    logic [7:0] lo;
    logic [6:0] folded;
    logic [7:0] code;
    logic [7:0] s2;
    logic       unsup;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_set <= hkpc_pkg::SET_2;
        end else if (i_cfg_wr) begin
            r_scan_set <= i_cfg_scan_set;
        end
    end

    assign ext = i_host_code[8];
    assign lo  = i_host_code[7:0];

    always_comb begin
        // fold upper-case letters onto lower case
        folded = i_virtual_key[6:0];
        if (i_virtual_key[6:0] >= 7'h41 && i_virtual_key[6:0] <= 7'h5a) begin
            folded = i_virtual_key[6:0] + 7'h20;
        end

        unsup = 1'b0;
        if (lo != 8'h00 && lo <= hkpc_pkg::DIRECT_MAX) begin
            code = lo;
        end else begin
            code = hkpc_pkg::ascii_code(folded);
            if (i_virtual_key[15:7] != 9'd0 || code == 8'h00) begin
                unsup = 1'b1;
            end
        end
        s2 = hkpc_pkg::set2_code(code);

        o_desc        = '0;
        o_desc.set2   = r_scan_set;
        o_desc.nbytes = 4'd1;

        if (i_virtual_key == hkpc_pkg::VK_PAUSE) begin
            if (!i_key_down) begin
                o_desc.empty  = 1'b1;
                o_desc.status = hkpc_pkg::STATUS_OK;
            end else begin
                o_desc.pause  = 1'b1;
                o_desc.nbytes = (r_scan_set == hkpc_pkg::SET_2) ?
                                hkpc_pkg::PAUSE_LEN_S2 : hkpc_pkg::PAUSE_LEN_S1;
            end
        end else if (unsup || (r_scan_set == hkpc_pkg::SET_2 && s2 == 8'h00)) begin
            o_desc.empty  = 1'b1;
            o_desc.status = hkpc_pkg::STATUS_UNSUP;
        end else if (r_scan_set == hkpc_pkg::SET_1) begin
            if (ext) begin
                o_desc.b0     = hkpc_pkg::PFX_EXT;
                o_desc.b1     = i_key_down ? code : (code | hkpc_pkg::S1_BREAK);
                o_desc.nbytes = 4'd2;
            end else begin
                o_desc.b0     = i_key_down ? code : (code | hkpc_pkg::S1_BREAK);
            end
        end else begin
            case ({ext, i_key_down})
                2'b11: begin
                    o_desc.b0     = hkpc_pkg::PFX_EXT;
                    o_desc.b1     = s2;
                    o_desc.nbytes = 4'd2;
                end
                2'b10: begin
                    o_desc.b0     = hkpc_pkg::PFX_EXT;
                    o_desc.b1     = hkpc_pkg::PFX_BREAK;
                    o_desc.b2     = s2;
                    o_desc.nbytes = 4'd3;
                end
                2'b00: begin
                    o_desc.b0     = hkpc_pkg::PFX_BREAK;
                    o_desc.b1     = s2;
                    o_desc.nbytes = 4'd2;
                end
                default: begin
                    o_desc.b0     = s2;
                end
            endcase
        end
    end

endmodule

/* hdl/hkpc_queue.sv */
`timescale 1ns / 1ps
// ============================================================================
// hkpc_queue
// Two-entry descriptor queue between classifier and emitter.
// ============================================================================
module hkpc_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  hkpc_pkg::t_desc     i_desc,
    input  logic                i_pop,
    output logic                o_full,
    output logic                o_valid,
    output hkpc_pkg::t_desc     o_desc,
    output logic [1:0]          o_count
);

    hkpc_pkg::t_desc r_mem [0:1];
    logic            r_wr_ptr;
    logic            r_rd_ptr;
    logic [1:0]      r_count;
    logic [1:0]      n_count;

    always_comb begin
        n_count = r_count;
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 2'd1;
            2'b01:   n_count = r_count - 2'd1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_desc;
        end
    end

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_desc  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

/* hdl/hkpc_back.sv */
`timescale 1ns / 1ps
// ============================================================================
// hkpc_back
// Emitter: walks the head descriptor one byte per cycle into the result
// registers.
// ============================================================================
module hkpc_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  hkpc_pkg::t_desc     i_desc,
    output logic                o_pop,
    output logic                o_strobe,
    output logic [7:0]          o_code_byte,
    output logic                o_byte_valid,
    output logic                o_status,
    output logic                o_last
);

    logic [2:0] r_idx;
    logic       r_strobe;
    logic [7:0] r_code_byte;
    logic       r_byte_valid;
    logic       r_status;
    logic       r_last;
    logic       last_now;
    logic [7:0] byte_now;

    assign last_now = ({1'b0, r_idx} == (i_desc.nbytes - 4'd1));
    assign o_pop    = i_valid && last_now;

    always_comb begin
        if (i_desc.empty) begin
            byte_now = 8'h00;
        end else if (i_desc.pause) begin
            byte_now = hkpc_pkg::pause_byte(i_desc.set2, r_idx);
        end else begin
            case (r_idx[1:0])
                2'd0:    byte_now = i_desc.b0;
                2'd1:    byte_now = i_desc.b1;
                default: byte_now = i_desc.b2;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= 3'd0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_valid;
            // advance within the event, restart at its final beat
            if (i_valid) begin
                r_idx <= last_now ? 3'd0 : r_idx + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_code_byte  <= byte_now;
        r_byte_valid <= ~i_desc.empty;
        r_status     <= i_desc.status;
        r_last       <= last_now;
    end

    assign o_strobe     = r_strobe;
    assign o_code_byte  = r_code_byte;
    assign o_byte_valid = r_byte_valid;
    assign o_status     = r_status;
    assign o_last       = r_last;

endmodule

/* hdl/host_key_to_pc_scan_code_core.sv */
`timescale 1ns / 1ps
// ============================================================================
// host_key_to_pc_scan_code_core
// Translates host key events into PC keyboard scan code byte sequences.
// ============================================================================
// An event is taken when start is high and busy is low. Each event gives one
// to eight result beats, one per clock on o_strobe, and o_last marks its final
// beat. With the emitter idle, a taken event is first written into the queue
// and then into the emitter's result registers before its first beat is on the
// ports. While earlier events are still being sent it waits for them. The
// emitter puts out one byte per cycle; an event has one beat for a plain set 1
// make and up to eight for Pause in set 2. A two-entry queue sits in front of
// the emitter, so the next events are taken while one is still being sent.
// busy rises only when both entries are occupied. Results cannot be held off:
// sample every beat on o_strobe. Write scan_set only while idle.
// ============================================================================
module host_key_to_pc_scan_code_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_scan_set,
    input  logic        start,
    output logic        busy,
    input  logic [8:0]  i_host_code,
    input  logic [15:0] i_virtual_key,
    input  logic        i_key_down,
    output logic        o_strobe,
    output logic [7:0]  o_code_byte,
    output logic        o_byte_valid,
    output logic        o_status,
    output logic        o_last
);

    hkpc_pkg::t_desc front_desc;
    hkpc_pkg::t_desc head_desc;
    logic            push;
    logic            pop;
    logic            full;
    logic            head_valid;
    logic [1:0]      q_count;

    assign o_cfg_ready = 1'b1;
    assign busy        = full;
    assign push        = start && !full;

    hkpc_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr       (i_cfg_valid && o_cfg_ready),
        .i_cfg_scan_set (i_cfg_scan_set),
        .i_host_code    (i_host_code),
        .i_virtual_key  (i_virtual_key),
        .i_key_down     (i_key_down),
        .o_desc         (front_desc)
    );

    hkpc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (front_desc),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (head_valid),
        .o_desc  (head_desc),
        .o_count (q_count)
    );

    hkpc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (head_valid),
        .i_desc       (head_desc),
        .o_pop        (pop),
        .o_strobe     (o_strobe),
        .o_code_byte  (o_code_byte),
        .o_byte_valid (o_byte_valid),
        .o_status     (o_status),
        .o_last       (o_last)
    );

    // an event's beats come without gaps
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last |=> o_strobe)
        else $error("result sequence broken before its final beat");

    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_byte_valid |-> o_last && o_code_byte == 8'h00)
        else $error("empty result not a single final beat");

    a_unsup_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_status |-> !o_byte_valid)
        else $error("unsupported key produced a byte");

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count != 2'd3)
        else $error("descriptor queue overflow");

endmodule

/* tb/host_key_to_pc_scan_code_core_test.sv */
`timescale 1ns / 1ps
// ============================================================================
// host_key_to_pc_scan_code_core_test
// Self-checking bench for the host key to PC scan code translator. A queue of
// key events and scan set writes feeds a clocked driver. Each accepted event
// is translated by a local model into the byte beats it should produce, and a
// clocked monitor compares every strobed beat against the oldest one due.
// ============================================================================
module host_key_to_pc_scan_code_core_test;

    localparam int LIMIT  = 200000;
    localparam int SETTLE = 4;

    localparam logic [7:0]  LAST_DIRECT    = 8'h58;
    localparam logic [47:0] PAUSE_BYTES_S1 = 48'he1_1d_45_e1_9d_c5;
    localparam logic [63:0] PAUSE_BYTES_S2 = 64'he1_14_77_e1_f0_14_f0_77;

    localparam logic [7:0] SET2_MAKE [0:88] = '{
        8'h00, 8'h76, 8'h16, 8'h1e, 8'h26, 8'h25, 8'h2e, 8'h36,
        8'h3d, 8'h3e, 8'h46, 8'h45, 8'h4e, 8'h55, 8'h66, 8'h0d,
        8'h15, 8'h1d, 8'h24, 8'h2d, 8'h2c, 8'h35, 8'h3c, 8'h43,
        8'h44, 8'h4d, 8'h54, 8'h5b, 8'h5a, 8'h14, 8'h1c, 8'h1b,
        8'h23, 8'h2b, 8'h34, 8'h33, 8'h3b, 8'h42, 8'h4b, 8'h4c,
        8'h52, 8'h0e, 8'h12, 8'h5d, 8'h1a, 8'h22, 8'h21, 8'h2a,
        8'h32, 8'h31, 8'h3a, 8'h41, 8'h49, 8'h4a, 8'h59, 8'h7c,
        8'h11, 8'h29, 8'h58, 8'h05, 8'h06, 8'h04, 8'h0c, 8'h03,
        8'h0b, 8'h83, 8'h0a, 8'h01, 8'h09, 8'h77, 8'h7e, 8'h6c,
        8'h75, 8'h7d, 8'h7b, 8'h6b, 8'h73, 8'h74, 8'h79, 8'h69,
        8'h72, 8'h7a, 8'h70, 8'h71, 8'h00, 8'h00, 8'h00, 8'h78,
        8'h07
    };

    typedef struct packed {
        logic [7:0] code_byte;
        logic       byte_valid;
        logic       status;
        logic       last;
    } t_scan_beat;

    typedef struct {
        bit          is_cfg;
        logic        set_val;
        logic [8:0]  hc;
        logic [15:0] vk;
        logic        down;
        bit          idle_ok;
    } t_key_job;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_scan_set = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [8:0]  i_host_code = '0;
    logic [15:0] i_virtual_key = '0;
    logic        i_key_down = 1'b0;
    logic        o_strobe;
    logic [7:0]  o_code_byte;
    logic        o_byte_valid;
    logic        o_status;
    logic        o_last;

    t_key_job   jobs_to_send [$];
    t_scan_beat beats_due [$];
    logic [7:0] ascii_make [0:127];
    logic       active_set;
    t_scan_beat got_beat;
    t_scan_beat want_beat;
    t_key_job   next_job;
    bit         failed = 1'b0;
    int         idle_left;
    int         quiet_cycles;
    int         cycle_count = 0;

    host_key_to_pc_scan_code_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_scan_set (i_cfg_scan_set),
        .start          (start),
        .busy           (busy),
        .i_host_code    (i_host_code),
        .i_virtual_key  (i_virtual_key),
        .i_key_down     (i_key_down),
        .o_strobe       (o_strobe),
        .o_code_byte    (o_code_byte),
        .o_byte_valid   (o_byte_valid),
        .o_status       (o_status),
        .o_last         (o_last)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic void queue_empty(input logic st);
        t_scan_beat b;
        b = '{code_byte: 8'h00, byte_valid: 1'b0, status: st, last: 1'b1};
        beats_due.push_back(b);
    endfunction

    function automatic void queue_bytes(input logic [7:0] seq [$]);
        t_scan_beat b;
        for (int k = 0; k < seq.size(); k++) begin
            b = '{code_byte: seq[k], byte_valid: 1'b1, status: hkpc_pkg::STATUS_OK,
                  last: (k == seq.size() - 1)};
            beats_due.push_back(b);
        end
    endfunction

    // Work out the beats that one key event must produce under active_set.
    function automatic void translate_key(input logic [8:0] hc, input logic [15:0] vk,
                                          input logic down);
        logic [7:0]  lo;
        logic [7:0]  code;
        logic [15:0] ch;
        logic [7:0]  seq [$];
        lo = hc[7:0];
        if (vk == hkpc_pkg::VK_PAUSE) begin
            if (!down) begin
                queue_empty(hkpc_pkg::STATUS_OK);
            end else if (active_set == hkpc_pkg::SET_1) begin
                for (int k = 0; k < 6; k++) seq.push_back(PAUSE_BYTES_S1[47 - 8 * k -: 8]);
                queue_bytes(seq);
            end else begin
                for (int k = 0; k < 8; k++) seq.push_back(PAUSE_BYTES_S2[63 - 8 * k -: 8]);
                queue_bytes(seq);
            end
            return;
        end
        if (lo != 8'h00 && lo <= LAST_DIRECT) begin
            code = lo;
        end else begin
            if (vk >= 16'd128) begin
                queue_empty(hkpc_pkg::STATUS_UNSUP);
                return;
            end
            ch = vk;
            // fold upper case onto lower case
            if (ch >= 16'h41 && ch <= 16'h5a) ch = ch + 16'h20;
            code = ascii_make[ch[6:0]];
            if (code == 8'h00) begin
                queue_empty(hkpc_pkg::STATUS_UNSUP);
                return;
            end
        end
        if (active_set == hkpc_pkg::SET_1) begin
            if (hc[8]) seq.push_back(hkpc_pkg::PFX_EXT);
            seq.push_back(down ? code : (code | hkpc_pkg::S1_BREAK));
            queue_bytes(seq);
            return;
        end
        if (code > LAST_DIRECT) begin
            queue_empty(hkpc_pkg::STATUS_UNSUP);
            return;
        end
        if (SET2_MAKE[code] == 8'h00) begin
            queue_empty(hkpc_pkg::STATUS_UNSUP);
            return;
        end
        if (hc[8]) seq.push_back(hkpc_pkg::PFX_EXT);
        if (!down) seq.push_back(hkpc_pkg::PFX_BREAK);
        seq.push_back(SET2_MAKE[code]);
        queue_bytes(seq);
    endfunction

    task automatic add_key(input logic [8:0] hc, input logic [15:0] vk, input logic down,
                           input bit idle_ok);
        t_key_job j;
        j = '{is_cfg: 1'b0, set_val: 1'b0, hc: hc, vk: vk, down: down, idle_ok: idle_ok};
        jobs_to_send.push_back(j);
    endtask

    task automatic add_set(input logic val);
        t_key_job j;
        j = '{is_cfg: 1'b1, set_val: val, hc: '0, vk: '0, down: 1'b0, idle_ok: 1'b1};
        jobs_to_send.push_back(j);
    endtask

    // Mostly well-formed keys, some ASCII fallbacks, some Pause, some noise.
    task automatic add_random_key(input bit idle_ok);
        int          pick;
        logic [8:0]  hc;
        logic [15:0] vk;
        pick = int'($urandom_range(0, 15));
        hc = 9'($urandom);
        vk = 16'($urandom);
        if (pick < 2) begin
            vk = hkpc_pkg::VK_PAUSE;
        end else if (pick < 10) begin
            hc[7:0] = 8'($urandom_range(1, 8'h58));
            if (vk == hkpc_pkg::VK_PAUSE) vk = vk ^ 16'h0100;
        end else if (pick < 13) begin
            hc[7:0] = $urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(8'h59, 8'hff));
            vk = 16'($urandom_range(0, 127));
            if (vk == hkpc_pkg::VK_PAUSE) vk = 16'h0041;
        end
        add_key(hc, vk, 1'($urandom), idle_ok);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            i_cfg_valid <= 1'b0;
            active_set = hkpc_pkg::SET_2;
            idle_left = 0;
            quiet_cycles = 0;
        end else begin
            if (start && !busy) translate_key(i_host_code, i_virtual_key, i_key_down);
            if (i_cfg_valid && o_cfg_ready) active_set = i_cfg_scan_set;
            if (beats_due.size() == 0) begin
                if (quiet_cycles < SETTLE) quiet_cycles = quiet_cycles + 1;
            end else begin
                quiet_cycles = 0;
            end

            if ((start && busy) || (i_cfg_valid && !o_cfg_ready)) begin
                // hold the request until it is taken
            end else if (idle_left != 0) begin
                start <= 1'b0;
                i_cfg_valid <= 1'b0;
                idle_left = idle_left - 1;
            end else if (jobs_to_send.size() == 0) begin
                start <= 1'b0;
                i_cfg_valid <= 1'b0;
            end else if (jobs_to_send[0].is_cfg) begin
                start <= 1'b0;
                // write the scan set only once every beat has drained
                if (quiet_cycles >= SETTLE && !start) begin
                    next_job = jobs_to_send.pop_front();
                    i_cfg_scan_set <= next_job.set_val;
                    i_cfg_valid <= 1'b1;
                end else begin
                    i_cfg_valid <= 1'b0;
                end
            end else if (jobs_to_send[0].idle_ok && $urandom_range(0, 3) == 0) begin
                start <= 1'b0;
                i_cfg_valid <= 1'b0;
                idle_left = int'($urandom_range(0, 18));
            end else begin
                next_job = jobs_to_send.pop_front();
                i_cfg_valid <= 1'b0;
                i_host_code <= next_job.hc;
                i_virtual_key <= next_job.vk;
                i_key_down <= next_job.down;
                start <= 1'b1;
            end
        end
    end

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            failed = 1'b1;
        end
    endfunction

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            got_beat = '{code_byte: o_code_byte, byte_valid: o_byte_valid,
                         status: o_status, last: o_last};
            if (beats_due.size() == 0) begin
                $display("%0t: beat expected none actual %0h/%0b/%0b/%0b", $time,
                         got_beat.code_byte, got_beat.byte_valid, got_beat.status,
                         got_beat.last);
                failed = 1'b1;
            end else begin
                want_beat = beats_due.pop_front();
                check_field("code_byte", want_beat.code_byte, got_beat.code_byte);
                check_field("byte_valid", want_beat.byte_valid, got_beat.byte_valid);
                check_field("status", want_beat.status, got_beat.status);
                check_field("last", want_beat.last, got_beat.last);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        for (int k = 0; k < 128; k++) ascii_make[k] = 8'h00;
        ascii_make[8'h08] = 8'h0e; ascii_make[8'h09] = 8'h0f; ascii_make[8'h0d] = 8'h1c;
        ascii_make[8'h1b] = 8'h01; ascii_make[8'h20] = 8'h39; ascii_make[8'h27] = 8'h28;
        ascii_make[8'h2c] = 8'h33; ascii_make[8'h2d] = 8'h0c; ascii_make[8'h2e] = 8'h34;
        ascii_make[8'h2f] = 8'h35; ascii_make[8'h30] = 8'h0b; ascii_make[8'h31] = 8'h02;
        ascii_make[8'h32] = 8'h03; ascii_make[8'h33] = 8'h04; ascii_make[8'h34] = 8'h05;
        ascii_make[8'h35] = 8'h06; ascii_make[8'h36] = 8'h07; ascii_make[8'h37] = 8'h08;
        ascii_make[8'h38] = 8'h09; ascii_make[8'h39] = 8'h0a; ascii_make[8'h3b] = 8'h27;
        ascii_make[8'h3d] = 8'h0d; ascii_make[8'h5b] = 8'h1a; ascii_make[8'h5c] = 8'h2b;
        ascii_make[8'h5d] = 8'h1b; ascii_make[8'h60] = 8'h29; ascii_make[8'h61] = 8'h1e;
        ascii_make[8'h62] = 8'h30; ascii_make[8'h63] = 8'h2e; ascii_make[8'h64] = 8'h20;
        ascii_make[8'h65] = 8'h12; ascii_make[8'h66] = 8'h21; ascii_make[8'h67] = 8'h22;
        ascii_make[8'h68] = 8'h23; ascii_make[8'h69] = 8'h17; ascii_make[8'h6a] = 8'h24;
        ascii_make[8'h6b] = 8'h25; ascii_make[8'h6c] = 8'h26; ascii_make[8'h6d] = 8'h32;
        ascii_make[8'h6e] = 8'h31; ascii_make[8'h6f] = 8'h18; ascii_make[8'h70] = 8'h19;
        ascii_make[8'h71] = 8'h10; ascii_make[8'h72] = 8'h13; ascii_make[8'h73] = 8'h1f;
        ascii_make[8'h74] = 8'h14; ascii_make[8'h75] = 8'h16; ascii_make[8'h76] = 8'h2f;
        ascii_make[8'h77] = 8'h11; ascii_make[8'h78] = 8'h2d; ascii_make[8'h79] = 8'h15;
        ascii_make[8'h7a] = 8'h2c;

        // set 2 out of reset: Pause, direct extremes, table holes, case folding
        add_key(9'h000, hkpc_pkg::VK_PAUSE, 1'b1, 1'b1);
        add_key(9'h1ff, hkpc_pkg::VK_PAUSE, 1'b0, 1'b1);
        add_key(9'h001, 16'h0000, 1'b1, 1'b1);
        add_key(9'h158, 16'hffff, 1'b0, 1'b1);
        add_key(9'h054, 16'h0041, 1'b1, 1'b1);
        add_key(9'h059, 16'h0041, 1'b1, 1'b1);
        add_key(9'h1ff, 16'h005a, 1'b0, 1'b1);
        add_key(9'h100, 16'h007f, 1'b1, 1'b1);
        add_key(9'h000, 16'h0080, 1'b1, 1'b1);
        add_key(9'h0ff, 16'h002f, 1'b0, 1'b1);
        add_key(9'h056, 16'h0000, 1'b1, 1'b1);
        add_key(9'h157, 16'h0013 ^ 16'h8000, 1'b0, 1'b1);
        // set 1: release marked by bit 7, set 2 holes become legal
        add_set(hkpc_pkg::SET_1);
        add_key(9'h1ff, hkpc_pkg::VK_PAUSE, 1'b1, 1'b1);
        add_key(9'h000, hkpc_pkg::VK_PAUSE, 1'b0, 1'b1);
        add_key(9'h158, 16'h0000, 1'b0, 1'b1);
        add_key(9'h001, 16'hffff, 1'b1, 1'b1);
        add_key(9'h054, 16'h0000, 1'b0, 1'b1);
        add_key(9'h000, 16'h001b, 1'b0, 1'b1);
        add_key(9'h180, 16'h0040, 1'b1, 1'b1);
        add_key(9'h059, 16'hffff, 1'b1, 1'b1);

        for (int p = 0; p < 4; p++) begin
            add_set(p[0] ? hkpc_pkg::SET_2 : hkpc_pkg::SET_1);
            for (int n = 0; n < 22; n++) add_random_key(!(p == 3 && n >= 4));
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (jobs_to_send.size() != 0 || start || i_cfg_valid || beats_due.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (!failed) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
